@@ design/egbr_pkg.sv @@
// Package for the Exp-Golomb bit reader: word types, request and status codes,
// store geometry and the controller to datapath command and status structs.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package egbr_pkg;

    // Store geometry. The byte count must be a power of two.
    localparam int STORE_BYTES = 4096;
    localparam int STORE_AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // Request codes.
    localparam logic [2:0] REQ_LOAD = 3'd0;
    localparam logic [2:0] REQ_SEEK = 3'd1;
    localparam logic [2:0] REQ_BITS = 3'd2;
    localparam logic [2:0] REQ_UE   = 3'd3;
    localparam logic [2:0] REQ_SE   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SIZE  = 2'd2;

    // Largest read and largest count of leading zeros.
    localparam logic [5:0] MAX_BITS = 6'd32;

    // Incoming request word.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] byte_addr;
        logic [7:0]  byte_value;
        logic [5:0]  bit_count;
        logic [14:0] seek_position;
    } t_in_word;

    // Outgoing result word.
    typedef struct packed {
        logic [31:0] value_bits;
        logic [1:0]  status;
        logic [15:0] bit_position;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch a new request and clear the working registers
        logic exec;     // load, seek, or check the read size
        logic zeros;    // one step of the leading-zero count
        logic bits;     // one step of the bit read
        logic base;     // add the Exp-Golomb offset
        logic emit;     // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_bits;     // request is a plain bit read
        logic is_golomb;   // request is an unsigned or signed Exp-Golomb read
        logic cnt_bad;     // bit count above the maximum
        logic at_end;      // cursor has reached the configured length
        logic need_zero;   // no bits left to read
        logic zeros_done;  // this step ends the leading-zero count
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/egbr_datapath.sv @@
// Datapath of the Exp-Golomb bit reader: byte store, cursor, length register,
// accumulator and result register. Takes egbr_pkg; driven by egbr_ctrl.
`default_nettype none

module egbr_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire egbr_pkg::t_in_word i_in_word,
    input  wire logic               i_cfg_valid,
    input  wire logic [15:0]        i_cfg_data,
    input  wire egbr_pkg::t_dp_cmd  i_cmd,
    output egbr_pkg::t_dp_stat      o_stat,
    output egbr_pkg::t_out_word     o_out_word
);

    localparam logic [5:0] MAX_BITS_C = egbr_pkg::MAX_BITS;

    // Byte store; contents are undefined until loaded.
    logic [7:0] r_mem [egbr_pkg::STORE_BYTES];
    logic [7:0] r_byte;

    // Working registers.
    egbr_pkg::t_in_word  r_req;
    egbr_pkg::t_out_word r_out;
    logic [15:0] r_cursor, n_cursor;
    logic [15:0] r_len;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_need, n_need;
    logic [5:0]  r_zeros, n_zeros;
    logic [1:0]  r_status, n_status;

    // Step logic.
    logic [2:0]  off;
    logic [3:0]  in_byte;
    logic [15:0] avail;
    logic [3:0]  avail_c;
    logic [7:0]  shifted;
    logic        at_end;
    logic [3:0]  need_c;
    logic [3:0]  take;
    logic [7:0]  bits_val;
    logic [31:0] acc_next;
    logic [5:0]  lim;
    logic [3:0]  lim_c;
    logic [3:0]  win;
    logic [3:0]  lz8;
    logic        found;
    logic [3:0]  z_take;
    logic [3:0]  z_add;
    logic [5:0]  zeros_new;
    logic        zeros_done;
    logic        cnt_bad;
    logic        mem_we;
    logic [15:0] wr_addr16;
    logic [31:0] rd_word;
    logic [31:0] base_mask;
    logic [31:0] se_pos;
    logic [31:0] se_val;
    logic [31:0] out_val;

    // Window of the current byte that the next step may consume.
    always_comb begin
        off     = r_cursor[2:0];
        in_byte = 4'd8 - {1'b0, off};
        at_end  = (r_cursor >= r_len);
        avail   = r_len - r_cursor;
        avail_c = (avail >= 16'd8) ? 4'd8 : avail[3:0];
        shifted = r_byte << off;
    end

    // Bit read step: take up to one byte's worth of the remaining bits.
    always_comb begin
        need_c = (r_need >= 6'd8) ? 4'd8 : r_need[3:0];
        take   = need_c;
        if (in_byte < take) begin
            take = in_byte;
        end
        if (avail_c < take) begin
            take = avail_c;
        end
        bits_val = shifted >> (4'd8 - take);
        acc_next = (r_acc << take) | 32'(bits_val);
    end

    // Leading-zero step: find the first one bit within the window.
    always_comb begin
        lim   = MAX_BITS_C - r_zeros;
        lim_c = (lim >= 6'd8) ? 4'd8 : lim[3:0];
        win   = in_byte;
        if (avail_c < win) begin
            win = avail_c;
        end
        if (lim_c < win) begin
            win = lim_c;
        end
        lz8 = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (shifted[i]) begin
                lz8 = 4'(7 - i);
            end
        end
        found      = (lz8 < win);
        z_take     = found ? (lz8 + 4'd1) : win;
        z_add      = found ? lz8 : win;
        zeros_new  = r_zeros + 6'(z_add);
        zeros_done = found || (zeros_new == MAX_BITS_C);
    end

    // Request decode and offset.
    always_comb begin
        cnt_bad   = (r_req.bit_count > MAX_BITS_C);
        wr_addr16 = 16'(r_req.byte_addr);
        base_mask = ~(32'hFFFF_FFFF << r_zeros);
    end

    // Next state of the working registers.
    always_comb begin
        n_cursor = r_cursor;
        n_acc    = r_acc;
        n_need   = r_need;
        n_zeros  = r_zeros;
        n_status = r_status;
        mem_we   = 1'b0;
        if (i_cmd.capture) begin
            n_acc    = '0;
            n_need   = '0;
            n_zeros  = '0;
            n_status = egbr_pkg::ST_OK;
        end
        if (i_cmd.exec) begin
            unique case (r_req.req_type)
                egbr_pkg::REQ_LOAD: begin
                    mem_we = (32'(r_req.byte_addr) < egbr_pkg::STORE_BYTES);
                end
                egbr_pkg::REQ_SEEK: begin
                    if ({1'b0, r_req.seek_position} < r_len) begin
                        n_cursor = {1'b0, r_req.seek_position};
                    end else begin
                        n_status = egbr_pkg::ST_RANGE;
                    end
                end
                egbr_pkg::REQ_BITS: begin
                    if (cnt_bad) begin
                        n_status = egbr_pkg::ST_SIZE;
                    end else begin
                        n_need = r_req.bit_count;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.zeros) begin
            if (at_end) begin
                n_status = egbr_pkg::ST_RANGE;
            end else begin
                n_cursor = r_cursor + 16'(z_take);
                n_zeros  = zeros_new;
                if (zeros_done) begin
                    n_need = zeros_new;
                end
            end
        end
        if (i_cmd.bits && (r_need != 6'd0)) begin
            if (at_end) begin
                n_status = egbr_pkg::ST_RANGE;
            end else begin
                n_cursor = r_cursor + 16'(take);
                n_acc    = acc_next;
                n_need   = r_need - 6'(take);
            end
        end
        if (i_cmd.base) begin
            n_acc = r_acc + base_mask;
        end
    end

    // Control registers: cursor, length, status and the step counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_len    <= '0;
            r_status <= egbr_pkg::ST_OK;
            r_need   <= '0;
            r_zeros  <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_status <= n_status;
            r_need   <= n_need;
            r_zeros  <= n_zeros;
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_cmd.capture) begin
            r_req <= i_in_word;
        end
    end

    // Byte store: one write port for loads, one registered read port that
    // follows the next cursor so the current byte is always on hand.
    always_comb begin
        rd_word = 32'(n_cursor >> 3);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr16[egbr_pkg::STORE_AW-1:0]] <= r_req.byte_value;
        end
        r_byte <= r_mem[rd_word[egbr_pkg::STORE_AW-1:0]];
    end

    // Result value with the signed mapping applied.
    always_comb begin
        se_pos = r_acc + 32'd1;
        se_val = r_acc[0] ? (se_pos >> 1) : (32'd0 - (r_acc >> 1));
        if (r_status != egbr_pkg::ST_OK) begin
            out_val = '0;
        end else if (r_req.req_type == egbr_pkg::REQ_SE) begin
            out_val = se_val;
        end else begin
            out_val = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.value_bits   <= out_val;
            r_out.status       <= r_status;
            r_out.bit_position <= r_cursor;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_stat.is_bits    = (r_req.req_type == egbr_pkg::REQ_BITS);
        o_stat.is_golomb  = (r_req.req_type == egbr_pkg::REQ_UE) ||
                            (r_req.req_type == egbr_pkg::REQ_SE);
        o_stat.cnt_bad    = cnt_bad;
        o_stat.at_end     = at_end;
        o_stat.need_zero  = (r_need == 6'd0);
        o_stat.zeros_done = zeros_done;
    end

    assign o_out_word = r_out;

`ifndef NO_ASSERTIONS
    // Counters never pass the largest code length.
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zeros <= MAX_BITS_C) && (r_need <= MAX_BITS_C))
        else $error("zero count or remaining bits above the maximum");

    // Once an error is recorded it holds until the next request.
    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_status != egbr_pkg::ST_OK) && !i_cmd.capture) |=> (r_status == $past(r_status)))
        else $error("error status changed before the next request");
`endif

endmodule

`default_nettype wire

@@ design/egbr_ctrl.sv @@
// Controller of the Exp-Golomb bit reader: request sequencing, input stall and
// result valid. Takes egbr_pkg; issues commands to egbr_datapath.
`default_nettype none

module egbr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire egbr_pkg::t_dp_stat i_stat,
    output egbr_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ZEROS,
        S_BITS,
        S_BASE,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    // The result register is free when empty or being taken this cycle.
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        accept   = (r_state == S_IDLE) && i_in_valid;
    end

    // Commands and next state.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_bits && !i_stat.cnt_bad) begin
                    n_state = S_BITS;
                end else if (i_stat.is_golomb) begin
                    n_state = S_ZEROS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ZEROS: begin
                o_cmd.zeros = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end else if (i_stat.zeros_done) begin
                    n_state = S_BITS;
                end
            end
            S_BITS: begin
                o_cmd.bits = 1'b1;
                if (i_stat.need_zero) begin
                    n_state = i_stat.is_golomb ? S_BASE : S_DONE;
                end else if (i_stat.at_end) begin
                    n_state = S_DONE;
                end
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on emit, cleared once the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // An accepted request always moves on to execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not start execution");

    // Running off the end during the zero count ends the request.
    a_zero_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ZEROS) && i_stat.at_end) |=> (r_state == S_DONE))
        else $error("zero count did not stop at the end of the stream");

    // A result loaded into the output register is offered next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_out_valid)
        else $error("emitted result not offered");
`endif

endmodule

`default_nettype wire

@@ design/exp_golomb_bit_reader_unit.sv @@
// Top level of the Exp-Golomb bit reader: joins egbr_ctrl and egbr_datapath.
// Takes egbr_pkg for the word types and command and status structs.
`default_nettype none

// MSB-first bit reader over a 4096-byte store with unsigned and signed
// Exp-Golomb decoding. Each request word gives exactly one result word. A load,
// seek or unknown request passes through the execute and done states before
// its result is loaded into the result register, which waits while that
// register is full. Reads are worked through one stored byte per cycle: a plain
// read of n bits steps through each byte it touches (up to five bytes for 32
// bits), and a Golomb code steps through each byte touched by its zero prefix
// and then each byte touched by its suffix. The next word is accepted only once
// the block is back in idle after its result is loaded. The store has one
// registered read port that tracks the cursor, which sets the
// one-byte-per-cycle pace. A new request is taken while the previous result
// still waits in the output register. The length register may be written only
// while no request is in flight; bytes never loaded read back as unknown.
module exp_golomb_bit_reader_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire egbr_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output egbr_pkg::t_out_word      o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [15:0]         i_cfg_data
);

    egbr_pkg::t_dp_cmd  cmd;
    egbr_pkg::t_dp_stat stat;

    // Sequencing.
    egbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Store, cursor and arithmetic.
    egbr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_word  (o_out_word)
    );

    // The length register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for exp_golomb_bit_reader_unit. It plans load, seek, bit
// and Exp-Golomb request words, predicts every result word and compares them.
// Depends on egbr_pkg and on the design files of the bit reader.
`default_nettype none

module tb_top;

    // Request codes that the block does not decode.
    localparam logic [2:0]  REQ_FIRST_SPARE = 3'd5;
    localparam logic [2:0]  REQ_LAST_SPARE  = 3'd7;
    localparam int unsigned RANDOM_REQUESTS = 1600;
    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned MAX_SEEK        = 32767;
    localparam int unsigned FULL_LENGTH     = 32768;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    egbr_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    egbr_pkg::t_out_word out_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data  = '0;

    // Predicted state of the reader: byte store, cursor and configured length.
    logic [7:0]  stream_store [0:egbr_pkg::STORE_BYTES-1];
    logic [15:0] stream_cursor = '0;
    logic [15:0] stream_length = '0;

    // Planning state: which bytes hold loaded data and where the cursor can be.
    bit          plan_loaded [0:egbr_pkg::STORE_BYTES-1];
    int unsigned plan_len = 0;
    int unsigned plan_lo  = 0;
    int unsigned plan_hi  = 0;
    int unsigned requests_planned = 0;

    egbr_pkg::t_in_word  requests_pending [$];
    egbr_pkg::t_out_word results_due [$];

    // Flow control knobs and counters of the driver, the monitor and the watchdog.
    bit          calm      = 1'b0;
    int unsigned send_odds = 4;
    int unsigned recv_odds = 4;
    bit          offered   = 1'b0;
    int unsigned send_gap  = 0;
    int unsigned recv_gap  = 0;
    int unsigned hold_left = 0;
    bit          held_once = 1'b0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    exp_golomb_bit_reader_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Take one stream bit at the cursor, MSB of each byte first.
    task automatic pull_bit(output bit ok, output bit b);
        logic [egbr_pkg::STORE_AW-1:0] idx;
        ok = (stream_cursor < stream_length);
        b  = 1'b0;
        if (ok) begin
            idx = stream_cursor[3 +: egbr_pkg::STORE_AW];
            b   = stream_store[idx][3'd7 - stream_cursor[2:0]];
            stream_cursor = stream_cursor + 16'd1;
        end
    endtask

    // Plain read of n bits; bits taken before a failure stay taken.
    task automatic read_field(input int unsigned n, output logic [1:0] st,
                              output logic [31:0] v);
        bit          ok;
        bit          b;
        int unsigned i;
        v  = '0;
        st = egbr_pkg::ST_OK;
        if (n > egbr_pkg::MAX_BITS) begin
            st = egbr_pkg::ST_SIZE;
        end else begin
            for (i = 0; i < n && st == egbr_pkg::ST_OK; i++) begin
                pull_bit(ok, b);
                if (!ok) begin
                    st = egbr_pkg::ST_RANGE;
                end else begin
                    v = {v[30:0], b};
                end
            end
        end
    endtask

    // Unsigned Exp-Golomb: the zero prefix stops at 32 without a terminating one.
    task automatic read_golomb(output logic [1:0] st, output logic [31:0] v);
        bit          ok;
        bit          b;
        bit          stop;
        int unsigned zeros;
        logic [31:0] rest;
        zeros = 0;
        stop  = 1'b0;
        st    = egbr_pkg::ST_OK;
        v     = '0;
        rest  = '0;
        while (zeros < egbr_pkg::MAX_BITS && !stop && st == egbr_pkg::ST_OK) begin
            pull_bit(ok, b);
            if (!ok) begin
                st = egbr_pkg::ST_RANGE;
            end else if (b) begin
                stop = 1'b1;
            end else begin
                zeros++;
            end
        end
        if (st == egbr_pkg::ST_OK) begin
            read_field(zeros, st, rest);
            if (st == egbr_pkg::ST_OK) begin
                v = rest + ((zeros < egbr_pkg::MAX_BITS) ? ((32'd1 << zeros) - 32'd1)
                                                         : 32'hFFFF_FFFF);
            end
        end
    endtask

    // Work out the result word of one accepted request word.
    task automatic decode_request(input egbr_pkg::t_in_word w,
                                  output egbr_pkg::t_out_word r);
        logic [31:0] v;
        logic [31:0] k;
        logic [1:0]  st;
        v  = '0;
        k  = '0;
        st = egbr_pkg::ST_OK;
        case (w.req_type)
            egbr_pkg::REQ_LOAD: begin
                if (w.byte_addr < egbr_pkg::STORE_BYTES) begin
                    stream_store[w.byte_addr] = w.byte_value;
                end
            end
            egbr_pkg::REQ_SEEK: begin
                if ({1'b0, w.seek_position} < stream_length) begin
                    stream_cursor = {1'b0, w.seek_position};
                end else begin
                    st = egbr_pkg::ST_RANGE;
                end
            end
            egbr_pkg::REQ_BITS: read_field(w.bit_count, st, v);
            egbr_pkg::REQ_UE:   read_golomb(st, v);
            egbr_pkg::REQ_SE: begin
                read_golomb(st, k);
                // Odd codes map to positive values, even codes to negated halves.
                if (st == egbr_pkg::ST_OK) begin
                    v = k[0] ? (k + 32'd1) >> 1 : 32'd0 - (k >> 1);
                end
            end
            default: ;
        endcase
        if (st != egbr_pkg::ST_OK) begin
            v = '0;
        end
        r.value_bits   = v;
        r.status       = st;
        r.bit_position = stream_cursor;
    endtask

    // Byte content biased towards zeros so that long Golomb prefixes turn up.
    function automatic logic [7:0] stream_byte();
        case ($urandom_range(0, 7)) inside
            [0:2]:   return 8'h00;
            3:       return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom);
        endcase
    endfunction

    // Queue one request word. Before a read, every byte that the read could touch
    // gets a load first, so that no byte is read before it was written.
    task automatic put_req(input logic [2:0] req, input int unsigned a, input int unsigned b);
        egbr_pkg::t_in_word w;
        egbr_pkg::t_in_word fill;
        logic [63:0]        noise;
        int unsigned        reach;
        int unsigned        stop;
        int unsigned        idx;
        noise      = {$urandom, $urandom};
        w          = noise[$bits(egbr_pkg::t_in_word)-1:0];
        w.req_type = req;
        case (req) inside
            egbr_pkg::REQ_LOAD: begin
                w.byte_addr  = a[11:0];
                w.byte_value = b[7:0];
                plan_loaded[a[11:0]] = 1'b1;
            end
            egbr_pkg::REQ_SEEK: begin
                w.seek_position = a[14:0];
                if (a < plan_len) begin
                    plan_lo = a;
                    plan_hi = a;
                end
            end
            egbr_pkg::REQ_BITS, egbr_pkg::REQ_UE, egbr_pkg::REQ_SE: begin
                if (req == egbr_pkg::REQ_BITS) begin
                    w.bit_count = a[5:0];
                    reach = (a <= egbr_pkg::MAX_BITS) ? a : 0;
                end else begin
                    reach = 64;
                end
                stop = plan_hi + reach;
                if (stop > plan_len) begin
                    stop = plan_len;
                end
                if (stop > plan_lo) begin
                    for (idx = plan_lo / 8; idx <= (stop - 1) / 8; idx++) begin
                        if (!plan_loaded[idx]) begin
                            fill            = '0;
                            fill.req_type   = egbr_pkg::REQ_LOAD;
                            fill.byte_addr  = idx[11:0];
                            fill.byte_value = stream_byte();
                            plan_loaded[idx] = 1'b1;
                            requests_pending.push_back(fill);
                            requests_planned++;
                        end
                    end
                end
                if (stop > plan_hi) begin
                    plan_hi = stop;
                end
            end
            default: ;
        endcase
        requests_pending.push_back(w);
        requests_planned++;
    endtask

    // One well-formed sequence: a few stray loads, a seek, then a run of reads.
    task automatic plan_sequence();
        int unsigned pos;
        repeat ($urandom_range(0, 2)) begin
            put_req(egbr_pkg::REQ_LOAD, $urandom_range(0, egbr_pkg::STORE_BYTES - 1),
                    stream_byte());
        end
        case ($urandom_range(0, 3))
            0: pos = $urandom_range(0, MAX_SEEK);
            // A seek to the length itself is refused.
            3: pos = (plan_len < FULL_LENGTH) ? plan_len : $urandom_range(0, MAX_SEEK);
            default: pos = (plan_len > 48) ? plan_len - $urandom_range(1, 48)
                                           : $urandom_range(0, 47);
        endcase
        put_req(egbr_pkg::REQ_SEEK, pos, 0);
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 15)) inside
                [0:5]:   put_req(egbr_pkg::REQ_BITS, $urandom_range(0, 32), 0);
                6:       put_req(egbr_pkg::REQ_BITS, $urandom_range(33, 63), 0);
                [7:10]:  put_req(egbr_pkg::REQ_UE, 0, 0);
                [11:14]: put_req(egbr_pkg::REQ_SE, 0, 0);
                default: put_req(3'($urandom_range(REQ_FIRST_SPARE, REQ_LAST_SPARE)), 0, 0);
            endcase
        end
    endtask

    // Hold the sender back until every word is accepted and every result is in.
    task automatic wait_until_idle();
        while (requests_pending.size() != 0 || offered || results_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the length register; only called while the block is idle.
    task automatic write_length(input logic [15:0] len);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        stream_length = len;
        plan_len      = len;
    endtask

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 12;
        endcase
    endfunction

    // Request driver: offers pending words and predicts each one as it is taken.
    always @(posedge clk) begin : request_driver
        egbr_pkg::t_out_word due;
        if (!rst_n) begin
            in_valid <= 1'b0;
            offered   = 1'b0;
            send_gap  = 0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_request(in_word, due);
                results_due.push_back(due);
                offered = 1'b0;
            end
            if (!offered) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (requests_pending.size() != 0) begin
                    in_word  <= requests_pending.pop_front();
                    in_valid <= 1'b1;
                    offered   = 1'b1;
                    if (!calm && send_odds != 0 && $urandom_range(0, send_odds - 1) == 0) begin
                        send_gap = $urandom_range(1, 19);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result word with the oldest prediction.
    always @(posedge clk) begin : result_monitor
        egbr_pkg::t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with none outstanding:",
                                 results_seen,
                                 " value %h status %0d pos %0d",
                                 out_word.value_bits, out_word.status,
                                 out_word.bit_position);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (out_word.value_bits !== want.value_bits ||
                        out_word.status !== want.status ||
                        out_word.bit_position !== want.bit_position) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected value %h status %0d pos %0d,",
                                     results_seen, want.value_bits, want.status,
                                     want.bit_position,
                                     " got value %h status %0d pos %0d",
                                     out_word.value_bits, out_word.status,
                                     out_word.bit_position);
                        end
                    end
                end
            end
            // One long hold-off while plenty of words wait, so the block backs up.
            if (!held_once && results_seen > 300 && requests_pending.size() > 30) begin
                held_once = 1'b1;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (recv_gap != 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (!calm && recv_odds != 0 && $urandom_range(0, recv_odds - 1) == 0) begin
                    recv_gap = $urandom_range(1, 19);
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake completes for too long.
    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned plan_phase;
        int unsigned new_len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Length still at its reset value of zero: every read that needs a bit runs out of range.
        put_req(egbr_pkg::REQ_BITS, 0, 0);
        put_req(egbr_pkg::REQ_BITS, 33, 0);
        put_req(egbr_pkg::REQ_BITS, 63, 0);
        put_req(egbr_pkg::REQ_BITS, 1, 0);
        put_req(egbr_pkg::REQ_UE, 0, 0);
        put_req(egbr_pkg::REQ_SEEK, 0, 0);
        put_req(REQ_FIRST_SPARE, 0, 0);
        put_req(REQ_LAST_SPARE, 0, 0);
        // Eight zero bytes give a Golomb code with a full 32-bit zero prefix.
        for (i = 0; i < 8; i++) begin
            put_req(egbr_pkg::REQ_LOAD, i, 8'h00);
        end
        put_req(egbr_pkg::REQ_LOAD, 8, 8'hA5);
        put_req(egbr_pkg::REQ_LOAD, egbr_pkg::STORE_BYTES - 1, 8'hFF);
        wait_until_idle();

        // Full length: longest codes, the top of the store and reads past the end.
        write_length(16'(FULL_LENGTH));
        put_req(egbr_pkg::REQ_UE, 0, 0);
        put_req(egbr_pkg::REQ_SEEK, 0, 0);
        put_req(egbr_pkg::REQ_SE, 0, 0);
        put_req(egbr_pkg::REQ_SEEK, MAX_SEEK, 0);
        put_req(egbr_pkg::REQ_BITS, 1, 0);
        put_req(egbr_pkg::REQ_BITS, 32, 0);
        put_req(egbr_pkg::REQ_UE, 0, 0);
        put_req(egbr_pkg::REQ_SEEK, MAX_SEEK - 7, 0);
        put_req(egbr_pkg::REQ_BITS, 32, 0);

        // Random phases, each with its own length and flow control mix.
        requests_planned = 0;
        plan_phase       = 0;
        while (requests_planned < RANDOM_REQUESTS) begin
            wait_until_idle();
            case (plan_phase)
                0: new_len = 0;
                1: new_len = 1;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       new_len = FULL_LENGTH;
                        1:       new_len = $urandom_range(1, 96);
                        4:       new_len = 8 * $urandom_range(1, egbr_pkg::STORE_BYTES);
                        default: new_len = $urandom_range(1, FULL_LENGTH);
                    endcase
                end
            endcase
            write_length(new_len[15:0]);
            calm      = (requests_planned + 250 >= RANDOM_REQUESTS);
            send_odds = pick_odds();
            recv_odds = pick_odds();
            repeat ($urandom_range(8, 25)) begin
                plan_sequence();
            end
            plan_phase++;
        end
        wait_until_idle();
        repeat (20) @(posedge clk);

        mismatches += results_due.size();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
